// ===== hdl/egpsd_pkg.sv =====
// Shared types, constants and helper functions for the Elias gamma prefix-sum decoder.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps
`default_nettype none

package egpsd_pkg;

	localparam int WORD_BITS   = 64;
	localparam int POS_BITS    = 6;    // bit index inside a word
	localparam int LEN_BITS    = 7;    // zero-run / payload length, saturating
	localparam int OFFSET_BITS = 6;
	localparam int CNT_IN_BITS = 32;   // width of the count field on the port
	localparam int QDEPTH      = 4;    // front-to-back queue depth
	localparam int QPTR_BITS   = 2;
	localparam int QFILL_BITS  = 3;

	localparam logic [LEN_BITS-1:0] ZRUN_MAX  = 7'd127;
	localparam logic [LEN_BITS-1:0] WORD_LEN  = 7'd64;

	// What the back end must do with a queued word
	typedef enum logic [1:0] {
		KIND_START,   // first word of a query with a nonzero count
		KIND_CONT,    // follow-on word of the running query
		KIND_ZERO     // first word with a zero count: answer at once
	} kind_t;

	typedef struct packed {
		kind_t                    kind;
		logic [WORD_BITS-1:0]     word;
		logic [OFFSET_BITS-1:0]   offset;
		logic [CNT_IN_BITS-1:0]   count;
	} qentry_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef enum logic {
		PH_ZEROS,
		PH_PAYLOAD
	} phase_t;

	// Count of trailing zeros; WORD_LEN when the word is all zero
	function automatic logic [LEN_BITS-1:0] ctz64(input logic [WORD_BITS-1:0] v);
		logic [LEN_BITS-1:0] r;
		r = WORD_LEN;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = LEN_BITS'(i);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/egpsd_if.sv =====
// Channel interfaces of the decoder: code-word requests in, prefix-sum results out.
// Depends on egpsd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface egpsd_in_if;
	logic                                  valid;
	logic                                  ready;
	logic [egpsd_pkg::WORD_BITS-1:0]       data_word;
	logic                                  first_word;
	logic [egpsd_pkg::OFFSET_BITS-1:0]     start_offset;
	logic [egpsd_pkg::CNT_IN_BITS-1:0]     code_count;

	modport source(output valid, data_word, first_word, start_offset, code_count, input ready);
	modport sink(input valid, data_word, first_word, start_offset, code_count, output ready);
endinterface

interface egpsd_out_if;
	logic                                  valid;
	logic                                  ready;
	logic [egpsd_pkg::WORD_BITS-1:0]       prefix_sum;
	logic [egpsd_pkg::POS_BITS-1:0]        stop_bit;

	modport source(output valid, prefix_sum, stop_bit, input ready);
	modport sink(input valid, prefix_sum, stop_bit, output ready);
endinterface

`default_nettype wire

// ===== hdl/egpsd_front.sv =====
// Front end: accepts code-word requests, classifies them and queues them for the back end.
// Depends on egpsd_pkg and egpsd_if.
`timescale 1ns / 1ps
`default_nettype none

module egpsd_front #(
	parameter int COUNT_BITS = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	egpsd_in_if.sink                 words,
	output egpsd_pkg::qentry_t       q_head,
	output logic                     q_valid,
	input  wire logic                q_pop
);

	egpsd_pkg::qentry_t                     mem_q [egpsd_pkg::QDEPTH];
	logic [egpsd_pkg::QPTR_BITS-1:0]        wr_ptr_q;
	logic [egpsd_pkg::QPTR_BITS-1:0]        rd_ptr_q;
	logic [egpsd_pkg::QFILL_BITS-1:0]       fill_q;
	logic [COUNT_BITS-1:0]                  cnt_masked;
	egpsd_pkg::qentry_t                     entry;
	logic                                   push;
	logic                                   pop;

	// Classify the incoming request
	always_comb begin
		cnt_masked   = COUNT_BITS'(words.code_count);
		entry.word   = words.data_word;
		entry.offset = words.start_offset;
		entry.count  = words.code_count;
		if (!words.first_word) begin
			entry.kind = egpsd_pkg::KIND_CONT;
		end else if (cnt_masked == '0) begin
			entry.kind = egpsd_pkg::KIND_ZERO;
		end else begin
			entry.kind = egpsd_pkg::KIND_START;
		end
	end

	// Queue handshake
	assign words.ready = (fill_q != egpsd_pkg::QFILL_BITS'(egpsd_pkg::QDEPTH));
	assign q_valid     = (fill_q != '0);
	assign q_head      = mem_q[rd_ptr_q];
	assign push        = words.valid && words.ready;
	assign pop         = q_valid && q_pop;

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry;
		end
	end

	// Queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/egpsd_back.sv =====
// Back end: walks the queued words one code segment per cycle while the output register is free,
// keeps the running sum and holds the result in that register. Depends on egpsd_pkg and egpsd_if.
`timescale 1ns / 1ps
`default_nettype none

module egpsd_back #(
	parameter int COUNT_BITS = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire egpsd_pkg::qentry_t  q_head,
	input  wire logic                q_valid,
	output logic                     q_pop,
	egpsd_out_if.source              sums
);

	localparam int WB = egpsd_pkg::WORD_BITS;
	localparam int LB = egpsd_pkg::LEN_BITS;

	// Control registers
	egpsd_pkg::state_t           state_q, state_d;
	logic                        active_q, active_d;
	logic                        out_valid_q, out_valid_d;

	// Datapath registers
	logic [WB-1:0]               word_q, word_d;
	logic [LB-1:0]               pos_q, pos_d;
	logic [COUNT_BITS-1:0]       codes_left_q, codes_left_d;
	logic [WB-1:0]               sum_q, sum_d;
	egpsd_pkg::phase_t           phase_q, phase_d;
	logic [LB-1:0]               zero_run_q, zero_run_d;
	logic [LB-1:0]               pbl_q, pbl_d;
	logic [WB-1:0]               out_sum_q, out_sum_d;
	logic [egpsd_pkg::POS_BITS-1:0] out_stop_q, out_stop_d;

	// Step helpers
	logic                        out_free;
	logic [LB-1:0]               rem;
	logic [WB-1:0]               sh;
	logic [LB-1:0]               tz_one;
	logic [LB-1:0]               run_ones;
	logic [LB:0]                 zsum;
	logic [LB-1:0]               zsat;
	logic [LB-1:0]               take;
	logic [WB-1:0]               take_mask;
	logic [LB-1:0]               pay_idx;
	logic [WB-1:0]               contrib;
	logic [WB-1:0]               lead;
	logic [WB-1:0]               addend;
	logic                        finish;

	assign out_free = !out_valid_q || sums.ready;

	always_comb begin
		state_d      = state_q;
		active_d     = active_q;
		out_valid_d  = out_valid_q && !sums.ready;
		word_d       = word_q;
		pos_d        = pos_q;
		codes_left_d = codes_left_q;
		sum_d        = sum_q;
		phase_d      = phase_q;
		zero_run_d   = zero_run_q;
		pbl_d        = pbl_q;
		out_sum_d    = out_sum_q;
		out_stop_d   = out_stop_q;
		q_pop        = 1'b0;
		finish       = 1'b0;
		addend       = '0;

		// Segment decode relative to the current bit position
		rem       = egpsd_pkg::WORD_LEN - pos_q;
		sh        = word_q >> pos_q[egpsd_pkg::POS_BITS-1:0];
		tz_one    = egpsd_pkg::ctz64(sh);
		run_ones  = egpsd_pkg::ctz64(~sh);
		zsum      = {1'b0, zero_run_q} + {1'b0, ((sh == '0) ? rem : tz_one)};
		zsat      = zsum[LB] ? egpsd_pkg::ZRUN_MAX : zsum[LB-1:0];
		take      = (pbl_q < rem) ? pbl_q : rem;
		take_mask = (take >= egpsd_pkg::WORD_LEN) ? '1
			: ((WB'(1) << take[egpsd_pkg::POS_BITS-1:0]) - WB'(1));
		pay_idx   = zero_run_q - pbl_q;
		contrib   = (pay_idx < egpsd_pkg::WORD_LEN)
			? ((sh & take_mask) << pay_idx[egpsd_pkg::POS_BITS-1:0]) : '0;
		lead      = (zero_run_q < egpsd_pkg::WORD_LEN)
			? (WB'(1) << zero_run_q[egpsd_pkg::POS_BITS-1:0]) : '0;

		unique case (state_q)
			egpsd_pkg::ST_IDLE: begin
				// Take the next word from the queue
				if (q_valid && out_free) begin
					q_pop = 1'b1;
					word_d = q_head.word;
					unique case (q_head.kind)
						egpsd_pkg::KIND_ZERO: begin
							active_d    = 1'b0;
							out_valid_d = 1'b1;
							out_sum_d   = '0;
							out_stop_d  = q_head.offset;
						end
						egpsd_pkg::KIND_START: begin
							active_d     = 1'b1;
							pos_d        = LB'(q_head.offset);
							codes_left_d = COUNT_BITS'(q_head.count);
							sum_d        = '0;
							phase_d      = egpsd_pkg::PH_ZEROS;
							zero_run_d   = '0;
							pbl_d        = '0;
							state_d      = egpsd_pkg::ST_RUN;
						end
						egpsd_pkg::KIND_CONT: begin
							pos_d = '0;
							if (active_q) begin
								state_d = egpsd_pkg::ST_RUN;
							end
						end
						default: begin
							state_d = egpsd_pkg::ST_IDLE;
						end
					endcase
				end
			end

			egpsd_pkg::ST_RUN: begin
				if (out_free) begin
					if (phase_q == egpsd_pkg::PH_ZEROS && zero_run_q == '0 && sh[0]) begin
						// Run of one-bit codes, each worth 1
						if (codes_left_q <= COUNT_BITS'(run_ones)) begin
							addend = WB'(codes_left_q[LB-1:0]);
							pos_d  = pos_q + codes_left_q[LB-1:0];
							finish = 1'b1;
						end else begin
							addend       = WB'(run_ones);
							pos_d        = pos_q + run_ones;
							codes_left_d = codes_left_q - COUNT_BITS'(run_ones);
						end
					end else if (phase_q == egpsd_pkg::PH_ZEROS) begin
						// Leading zeros up to the marker bit, or to the end of the word
						zero_run_d = zsat;
						if (sh == '0) begin
							pos_d = egpsd_pkg::WORD_LEN;
						end else begin
							pos_d   = pos_q + tz_one + LB'(1);
							phase_d = egpsd_pkg::PH_PAYLOAD;
							pbl_d   = zsat;
						end
					end else begin
						// Payload bits go straight into the sum; they never overlap
						pos_d = pos_q + take;
						pbl_d = pbl_q - take;
						if (pbl_q == take) begin
							addend     = contrib | lead;
							phase_d    = egpsd_pkg::PH_ZEROS;
							zero_run_d = '0;
							if (codes_left_q == COUNT_BITS'(1)) begin
								finish = 1'b1;
							end else begin
								codes_left_d = codes_left_q - COUNT_BITS'(1);
							end
						end else begin
							addend = contrib;
						end
					end

					sum_d = sum_q + addend;
					if (finish) begin
						active_d    = 1'b0;
						out_valid_d = 1'b1;
						out_sum_d   = sum_d;
						out_stop_d  = pos_d[egpsd_pkg::POS_BITS-1:0];
						state_d     = egpsd_pkg::ST_IDLE;
					end else if (pos_d == egpsd_pkg::WORD_LEN) begin
						state_d = egpsd_pkg::ST_IDLE;
					end
				end
			end

			default: begin
				state_d = egpsd_pkg::ST_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= egpsd_pkg::ST_IDLE;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			active_q    <= active_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		word_q       <= word_d;
		pos_q        <= pos_d;
		codes_left_q <= codes_left_d;
		sum_q        <= sum_d;
		phase_q      <= phase_d;
		zero_run_q   <= zero_run_d;
		pbl_q        <= pbl_d;
		out_sum_q    <= out_sum_d;
		out_stop_q   <= out_stop_d;
	end

	assign sums.valid      = out_valid_q;
	assign sums.prefix_sum = out_sum_q;
	assign sums.stop_bit   = out_stop_q;

endmodule

`default_nettype wire

// ===== hdl/elias_gamma_prefix_sum_decoder.sv =====
// Top level of the Elias gamma prefix-sum decoder: front end with request queue, back end.
// Depends on egpsd_pkg, egpsd_if, egpsd_front and egpsd_back.
`timescale 1ns / 1ps
`default_nettype none

// Decodes Elias gamma codes from 64-bit words (LSB first) and returns the sum of the
// first code_count values, modulo 2^64, with the bit position just after the last code.
// Requests enter a four-deep queue, so up to four words are taken while the decoder is
// busy or a result waits. The decoder first takes a word from the queue, then handles one
// segment per cycle while the output register is free: a run of one-bit codes (any length), the
// leading zeros of a longer code, or its payload bits. A code longer than one bit thus
// takes a zeros step and a payload step, plus one more where it crosses into the next word.
// A zero count is answered straight from the queue, without any segment step.
// A result is held in an output register until taken; the decoder pauses while it is full.
module elias_gamma_prefix_sum_decoder #(
	parameter int COUNT_BITS = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	egpsd_in_if.sink        words,
	egpsd_out_if.source     sums
);

	egpsd_pkg::qentry_t q_head;
	logic               q_valid;
	logic               q_pop;

	// Request classification and queue
	egpsd_front #(
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.words   (words),
		.q_head  (q_head),
		.q_valid (q_valid),
		.q_pop   (q_pop)
	);

	// Code walker and result register
	egpsd_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_head  (q_head),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.sums    (sums)
	);

endmodule

`default_nettype wire

// ===== sim/egpsd_sum_checker.sv =====
// Scoreboard for the Elias gamma prefix-sum decoder: watches both channels,
// decodes each accepted word itself and compares every returned sum in order.
// Depends on egpsd_pkg and the channel interfaces in egpsd_if.
`timescale 1ns / 1ps

module egpsd_sum_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	egpsd_in_if       words,
	egpsd_out_if      sums,
	output int unsigned failures,
	output int unsigned pending
);

	typedef struct packed {
		logic [egpsd_pkg::WORD_BITS-1:0] sum;
		logic [egpsd_pkg::POS_BITS-1:0]  stop;
	} sum_result_t;

	sum_result_t expected_sums[$];
	sum_result_t oldest;

	// Decoder state as seen by the scoreboard
	logic                              query_on;
	logic [egpsd_pkg::CNT_IN_BITS-1:0] codes_left;
	logic [egpsd_pkg::WORD_BITS-1:0]   sum_acc;
	egpsd_pkg::phase_t                 phase;
	logic [egpsd_pkg::LEN_BITS-1:0]    zeros_seen;
	logic [egpsd_pkg::LEN_BITS-1:0]    payload_left;
	logic [egpsd_pkg::WORD_BITS-1:0]   payload;

	task automatic drop_code();
		phase        = egpsd_pkg::PH_ZEROS;
		zeros_seen   = '0;
		payload_left = '0;
		payload      = '0;
	endtask

	// Walk the word bit by bit and queue a sum when the count runs out
	task automatic decode_request(input logic [egpsd_pkg::WORD_BITS-1:0] word,
			input logic first, input logic [egpsd_pkg::OFFSET_BITS-1:0] offset,
			input logic [egpsd_pkg::CNT_IN_BITS-1:0] count);
		int unsigned                     pos;
		logic                            done;
		logic [egpsd_pkg::LEN_BITS-1:0]  j;
		logic [egpsd_pkg::WORD_BITS-1:0] lead;
		pos = 0;
		if (first) begin
			sum_acc  = '0;
			query_on = 1'b0;
			drop_code();
			if (count == '0) begin
				expected_sums.push_back({{egpsd_pkg::WORD_BITS{1'b0}}, offset});
				return;
			end
			codes_left = count;
			query_on   = 1'b1;
			pos        = offset;
		end else if (!query_on) begin
			return;
		end
		while (pos < egpsd_pkg::WORD_BITS) begin
			done = 1'b0;
			if (phase == egpsd_pkg::PH_ZEROS) begin
				if (!word[pos]) begin
					if (zeros_seen != egpsd_pkg::ZRUN_MAX)
						zeros_seen = zeros_seen + 1'b1;
				end else if (zeros_seen == '0) begin
					done = 1'b1;
				end else begin
					phase        = egpsd_pkg::PH_PAYLOAD;
					payload_left = zeros_seen;
					payload      = '0;
				end
			end else begin
				j = zeros_seen - payload_left;
				if (word[pos] && j < egpsd_pkg::WORD_LEN)
					payload[j[egpsd_pkg::POS_BITS-1:0]] = 1'b1;
				payload_left = payload_left - 1'b1;
				if (payload_left == '0)
					done = 1'b1;
			end
			if (done) begin
				// leading one weighs 2^L; it falls off the top for L >= 64
				lead = (zeros_seen < egpsd_pkg::WORD_LEN) ? (64'd1 << zeros_seen) : '0;
				sum_acc = sum_acc + lead + payload;
				drop_code();
				codes_left = codes_left - 1'b1;
				if (codes_left == '0) begin
					query_on = 1'b0;
					expected_sums.push_back({sum_acc, egpsd_pkg::POS_BITS'(pos + 1)});
					return;
				end
			end
			pos++;
		end
	endtask

	// Compare results first, then predict from the request taken at this edge
	always @(posedge clk) begin
		if (!arst_n) begin
			failures   = 0;
			pending   <= 0;
			query_on   = 1'b0;
			codes_left = '0;
			sum_acc    = '0;
			drop_code();
			expected_sums.delete();
		end else begin
			if (sums.valid && sums.ready) begin
				if (expected_sums.size() == 0) begin
					$display("%0t: unexpected result sum=%h stop=%0d", $time,
						sums.prefix_sum, sums.stop_bit);
					failures++;
				end else begin
					oldest = expected_sums.pop_front();
					if (sums.prefix_sum !== oldest.sum) begin
						$display("%0t: prefix_sum expected %h actual %h", $time,
							oldest.sum, sums.prefix_sum);
						failures++;
					end
					if (sums.stop_bit !== oldest.stop) begin
						$display("%0t: stop_bit expected %0d actual %0d", $time,
							oldest.stop, sums.stop_bit);
						failures++;
					end
				end
			end
			if (words.valid && words.ready)
				decode_request(words.data_word, words.first_word, words.start_offset,
					words.code_count);
			pending <= expected_sums.size();
		end
	end

endmodule

// ===== sim/elias_gamma_prefix_sum_decoder_tb.sv =====
// Top of the decoder testbench: clock, reset, code-word stimulus and the verdict.
// Depends on egpsd_pkg, egpsd_if, the decoder RTL and egpsd_sum_checker.
`timescale 1ns / 1ps

module elias_gamma_prefix_sum_decoder_tb;

	localparam int unsigned STALL_LIMIT  = 4000;
	localparam int unsigned PHASE_ITEMS  = 132;
	localparam int unsigned SETTLE_CYCLES = 200;
	localparam logic [egpsd_pkg::WORD_BITS-1:0] ALL_ONES = '1;
	localparam logic [egpsd_pkg::WORD_BITS-1:0] TOP_BIT  = 64'h8000_0000_0000_0000;

	logic        clk;
	logic        arst_n;
	int unsigned fail_count;
	int unsigned pending_sums;
	int unsigned src_idle_pct;
	int unsigned sink_stall_pct;
	int unsigned quiet_cycles;

	egpsd_in_if  words();
	egpsd_out_if sums();

	elias_gamma_prefix_sum_decoder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.words  (words),
		.sums   (sums)
	);

	egpsd_sum_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.words    (words),
		.sums     (sums),
		.failures (fail_count),
		.pending  (pending_sums)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Result side back-pressure
	always @(negedge clk) begin
		sums.ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// Watchdog: too long with no request or result moving
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if ((words.valid && words.ready) || (sums.valid && sums.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("elias_gamma_prefix_sum_decoder_tb: FAIL");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Word content with varied density so both short and long codes show up
	function automatic logic [egpsd_pkg::WORD_BITS-1:0] make_word();
		logic [egpsd_pkg::WORD_BITS-1:0] a;
		logic [egpsd_pkg::WORD_BITS-1:0] b;
		logic [egpsd_pkg::WORD_BITS-1:0] c;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		c = {$urandom, $urandom};
		case ($urandom_range(9))
			0, 1, 2, 3: return a;
			4, 5:       return a & b & c;
			6:          return $urandom_range(1) ? (64'd1 << $urandom_range(63)) : '0;
			7:          return a | b;
			8:          return ALL_ONES;
			default:    return '0;
		endcase
	endfunction

	task automatic send_word(input logic [egpsd_pkg::WORD_BITS-1:0] w, input logic first,
			input logic [egpsd_pkg::OFFSET_BITS-1:0] offset,
			input logic [egpsd_pkg::CNT_IN_BITS-1:0] count);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			words.valid <= 1'b0;
			@(negedge clk);
		end
		words.valid        <= 1'b1;
		words.data_word    <= w;
		words.first_word   <= first;
		words.start_offset <= offset;
		words.code_count   <= count;
		do @(posedge clk); while (!words.ready);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		words.valid <= 1'b0;
		while (pending_sums != 0)
			@(negedge clk);
	endtask

	// Queries of a few words each; large counts get cut short by the next query
	task automatic run_queries(input int unsigned n_items);
		int unsigned                       sent;
		int unsigned                       n_words;
		int unsigned                       pick;
		logic [egpsd_pkg::CNT_IN_BITS-1:0] cnt;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			if (pick < 5)
				cnt = '0;
			else if (pick < 12)
				cnt = $urandom;
			else if (pick < 20)
				cnt = 1;
			else
				cnt = $urandom_range(40, 2);
			n_words = $urandom_range(5, 1);
			for (int i = 0; i < n_words; i++)
				send_word(make_word(), i == 0,
					egpsd_pkg::OFFSET_BITS'($urandom_range(63)),
					(i == 0) ? cnt : $urandom);
			sent += n_words;
			// stray follow-on word, usually with no query open
			if ($urandom_range(9) == 0) begin
				send_word(make_word(), 1'b0,
					egpsd_pkg::OFFSET_BITS'($urandom_range(63)), $urandom);
				sent++;
			end
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		src_idle_pct       = 0;
		sink_stall_pct     = 0;
		words.valid        = 1'b0;
		words.data_word    = '0;
		words.first_word   = 1'b0;
		words.start_offset = '0;
		words.code_count   = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// zero counts answer at once with the start offset
		send_word(ALL_ONES, 1'b1, 6'd0, 32'd0);
		send_word('0, 1'b1, 6'd63, 32'd0);
		// follow-on word with no query open is dropped
		send_word(ALL_ONES, 1'b0, 6'd63, 32'hFFFF_FFFF);
		// 64 one-bit codes; stop position wraps to 0
		send_word(ALL_ONES, 1'b1, 6'd0, 32'd64);
		// single code at bit 63
		send_word(TOP_BIT, 1'b1, 6'd63, 32'd1);
		// L = 64: leading one drops out, payload is all ones
		send_word('0, 1'b1, 6'd0, 32'd1);
		send_word(ALL_ONES, 1'b0, 6'd0, 32'd0);
		send_word(ALL_ONES, 1'b0, 6'd0, 32'd0);
		// two L = 63 codes of maximum value: the sum wraps
		send_word(64'd1, 1'b1, 6'd1, 32'd2);
		send_word(ALL_ONES, 1'b0, 6'd0, 32'd0);
		send_word(TOP_BIT, 1'b0, 6'd0, 32'd0);
		send_word(ALL_ONES, 1'b0, 6'd0, 32'd0);
		// zero run saturates at 127, then a lone one
		send_word('0, 1'b1, 6'd0, 32'd2);
		send_word('0, 1'b0, 6'd0, 32'd0);
		send_word('0, 1'b0, 6'd0, 32'd0);
		send_word(ALL_ONES, 1'b0, 6'd0, 32'd0);
		send_word(ALL_ONES, 1'b0, 6'd0, 32'd0);
		send_word(64'd1, 1'b0, 6'd0, 32'd0);
		// new query aborts an unfinished one
		send_word('0, 1'b1, 6'd5, 32'd3);
		send_word(64'd1, 1'b1, 6'd0, 32'd1);
		// largest count, left unfinished until the next query
		send_word({$urandom, $urandom}, 1'b1, 6'd42, 32'hFFFF_FFFF);
		wait_drained();

		run_queries(PHASE_ITEMS);
		wait_drained();
		src_idle_pct = 58;
		run_queries(PHASE_ITEMS);
		wait_drained();
		src_idle_pct   = 0;
		sink_stall_pct = 58;
		run_queries(PHASE_ITEMS);
		wait_drained();
		src_idle_pct   = 16;
		sink_stall_pct = 16;
		run_queries(PHASE_ITEMS);
		wait_drained();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("elias_gamma_prefix_sum_decoder_tb: PASS");
		else
			$display("elias_gamma_prefix_sum_decoder_tb: FAIL");
		$finish;
	end

endmodule

// ===== elias_gamma_prefix_sum_decoder.f =====
hdl/egpsd_pkg.sv
hdl/egpsd_if.sv
hdl/egpsd_front.sv
hdl/egpsd_back.sv
hdl/elias_gamma_prefix_sum_decoder.sv
sim/egpsd_sum_checker.sv
sim/elias_gamma_prefix_sum_decoder_tb.sv
